>>> rtl/ftfp_pkg.sv
package ftfp_pkg;

   // fixed field widths
   localparam int NOW_W      = 63;
   localparam int FRAME_W    = 30;
   localparam int RUNS_W     = 4;
   localparam int LERP_W     = 17;
   localparam int WAKE_W     = 63;
   localparam int WIDE_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   // defaults for the top-level parameters
   localparam int TIME_BITS_DEF     = 64;
   localparam int FRACTION_BITS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIM_FRAME   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_FRAME  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CATCH_UP    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_CAPPED = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_BENCHMARK   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_STEP = CSR_IDX_W'(5);

   // register reset values
   localparam logic [FRAME_W-1:0] SIM_FRAME_RST  = FRAME_W'(28571428);
   localparam logic [FRAME_W-1:0] DISP_FRAME_RST = FRAME_W'(28571428);
   localparam logic [RUNS_W-1:0]  CATCH_UP_RST   = RUNS_W'(4);

   typedef struct packed {
      logic [FRAME_W-1:0] sim_frame;
      logic [FRAME_W-1:0] disp_frame;
      logic [FRAME_W-1:0] sim_eff;
      logic [FRAME_W-1:0] disp_eff;
      logic [RUNS_W-1:0]  catch_up;
      logic               display_capped;
      logic               benchmark;
      logic               single_step;
   } cfg_type;

   typedef struct packed {
      logic              done;
      logic              quo_big;
      logic [RUNS_W-1:0] quo_low;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELAPSE,
      ST_ACCUM,
      ST_DISP,
      ST_DIV,
      ST_SETTLE,
      ST_WAKE,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/ftfp_intf.sv
interface ftfp_req_if;
   logic                        valid;
   logic                        ready;
   logic [ftfp_pkg::NOW_W-1:0]  now_ns;

   modport source (output valid, output now_ns, input ready);
   modport sink   (input valid, input now_ns, output ready);
endinterface

interface ftfp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ftfp_pkg::RUNS_W-1:0]  sim_runs;
   logic                         display_run;
   logic [ftfp_pkg::LERP_W-1:0]  lerp_fraction;
   logic [ftfp_pkg::WAKE_W-1:0]  wake_time_ns;

   modport source (output valid, output sim_runs, output display_run,
                   output lerp_fraction, output wake_time_ns, input ready);
   modport sink   (input valid, input sim_runs, input display_run,
                   input lerp_fraction, input wake_time_ns, output ready);
endinterface

>>> rtl/ftfp_csr.sv
module ftfp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ftfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ftfp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ftfp_pkg::cfg_type                   cfg
);

   logic [ftfp_pkg::FRAME_W-1:0] sim_frame_ff, sim_frame_in;
   logic [ftfp_pkg::FRAME_W-1:0] disp_frame_ff, disp_frame_in;
   logic [ftfp_pkg::RUNS_W-1:0]  catch_up_ff, catch_up_in;
   logic                         disp_capped_ff, disp_capped_in;
   logic                         benchmark_ff, benchmark_in;
   logic                         single_step_ff, single_step_in;

   always_comb begin
      sim_frame_in   = sim_frame_ff;
      disp_frame_in  = disp_frame_ff;
      catch_up_in    = catch_up_ff;
      disp_capped_in = disp_capped_ff;
      benchmark_in   = benchmark_ff;
      single_step_in = single_step_ff;
      if (csr_we) begin
         unique case (csr_index)
            ftfp_pkg::CSR_SIM_FRAME:   sim_frame_in   = csr_wdata[ftfp_pkg::FRAME_W-1:0];
            ftfp_pkg::CSR_DISP_FRAME:  disp_frame_in  = csr_wdata[ftfp_pkg::FRAME_W-1:0];
            ftfp_pkg::CSR_CATCH_UP:    catch_up_in    = csr_wdata[ftfp_pkg::RUNS_W-1:0];
            ftfp_pkg::CSR_DISP_CAPPED: disp_capped_in = csr_wdata[0];
            ftfp_pkg::CSR_BENCHMARK:   benchmark_in   = csr_wdata[0];
            ftfp_pkg::CSR_SINGLE_STEP: single_step_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sim_frame_ff   <= ftfp_pkg::SIM_FRAME_RST;
         disp_frame_ff  <= ftfp_pkg::DISP_FRAME_RST;
         catch_up_ff    <= ftfp_pkg::CATCH_UP_RST;
         disp_capped_ff <= 1'b1;
         benchmark_ff   <= 1'b0;
         single_step_ff <= 1'b0;
      end else begin
         sim_frame_ff   <= sim_frame_in;
         disp_frame_ff  <= disp_frame_in;
         catch_up_ff    <= catch_up_in;
         disp_capped_ff <= disp_capped_in;
         benchmark_ff   <= benchmark_in;
         single_step_ff <= single_step_in;
      end
   end

   // a zero frame duration acts as one nanosecond
   always_comb begin
      cfg.sim_frame      = sim_frame_ff;
      cfg.disp_frame     = disp_frame_ff;
      cfg.sim_eff        = (sim_frame_ff == '0) ? ftfp_pkg::FRAME_W'(1) : sim_frame_ff;
      cfg.disp_eff       = (disp_frame_ff == '0) ? ftfp_pkg::FRAME_W'(1) : disp_frame_ff;
      cfg.catch_up       = catch_up_ff;
      cfg.display_capped = disp_capped_ff;
      cfg.benchmark      = benchmark_ff;
      cfg.single_step    = single_step_ff;
   end

endmodule

>>> rtl/ftfp_div.sv
module ftfp_div #(
   parameter int TIME_BITS     = ftfp_pkg::TIME_BITS_DEF,
   parameter int FRACTION_BITS = ftfp_pkg::FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [TIME_BITS-1:0]               dividend,
   input  logic [ftfp_pkg::FRAME_W-1:0]       divisor,
   output ftfp_pkg::div_status_type           status,
   output logic [FRACTION_BITS-1:0]           frac,
   output logic [ftfp_pkg::FRAME_W-1:0]       rem
);

   // restoring division of dividend * 2^FRACTION_BITS, one quotient bit per cycle
   localparam int STEPS = TIME_BITS + FRACTION_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [TIME_BITS-1:0]          dvd_ff, dvd_in;
   logic [ftfp_pkg::FRAME_W-1:0]  rem_ff, rem_in;
   logic [ftfp_pkg::FRAME_W-1:0]  mod_ff, mod_in;
   logic [ftfp_pkg::RUNS_W-1:0]   qlo_ff, qlo_in;
   logic                          qbig_ff, qbig_in;
   logic [FRACTION_BITS-1:0]      frac_ff, frac_in;

   logic [ftfp_pkg::FRAME_W:0]    trial;
   logic [ftfp_pkg::FRAME_W:0]    diff;
   logic                          take;

   assign trial = {rem_ff, dvd_ff[TIME_BITS-1]};
   assign diff  = trial - {1'b0, divisor};
   assign take  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      qlo_in  = qlo_ff;
      qbig_in = qbig_ff;
      frac_in = frac_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         dvd_in  = dividend;
         rem_in  = '0;
         qlo_in  = '0;
         qbig_in = 1'b0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[TIME_BITS-2:0], 1'b0};
         rem_in  = take ? diff[ftfp_pkg::FRAME_W-1:0] : trial[ftfp_pkg::FRAME_W-1:0];
         frac_in = {frac_ff[FRACTION_BITS-2:0], take};
         // integer quotient only needs to be known up to 15; anything above is "big"
         if (cnt_ff > CNT_W'(FRACTION_BITS)) begin
            qbig_in = qbig_ff | qlo_ff[ftfp_pkg::RUNS_W-1];
            qlo_in  = {qlo_ff[ftfp_pkg::RUNS_W-2:0], take};
         end
         // dividend mod divisor, taken before the fraction bits are developed
         if (cnt_ff == CNT_W'(FRACTION_BITS + 1))
            mod_in = rem_in;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      mod_ff  <= mod_in;
      qlo_ff  <= qlo_in;
      qbig_ff <= qbig_in;
      frac_ff <= frac_in;
   end

   assign status.done    = done_ff;
   assign status.quo_big = qbig_ff;
   assign status.quo_low = qlo_ff;
   assign frac           = frac_ff;
   assign rem            = mod_ff;

endmodule

>>> rtl/fixed_timestep_frame_pacer.sv
// Channel   Dir  Handshake          Payload
// req_ch    in   valid/ready        now_ns
// rsp_ch    out  valid/ready        sim_runs, display_run, lerp_fraction, wake_time_ns
// csr_*     in   csr_we, no stall   csr_index, csr_wdata
//
// Requests are accepted only in the idle state, so the next request waits until
// the previous result is loaded into the output register; the serial divider
// produces one quotient bit per cycle.
// Reset restores the control and CSR registers and unprimes the accumulators.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only a second finished result stalls until rsp_ch.ready.
module fixed_timestep_frame_pacer #(
   parameter int TIME_BITS     = ftfp_pkg::TIME_BITS_DEF,
   parameter int FRACTION_BITS = ftfp_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ftfp_req_if.sink                          req_ch,
   ftfp_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [ftfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ftfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NOW_W  = ftfp_pkg::NOW_W;
   localparam int WIDE_W = ftfp_pkg::WIDE_W;
   localparam int WAKE_W = ftfp_pkg::WAKE_W;
   localparam int RUNS_W = ftfp_pkg::RUNS_W;
   localparam int LERP_W = ftfp_pkg::LERP_W;
   localparam int PROD_W = ftfp_pkg::RUNS_W + ftfp_pkg::FRAME_W;
   localparam int SUM_W  = ((TIME_BITS > NOW_W) ? TIME_BITS : NOW_W) + 1;

   ftfp_pkg::cfg_type                cfg;
   ftfp_pkg::div_status_type         div_st;
   logic [FRACTION_BITS-1:0]         div_frac;
   logic [ftfp_pkg::FRAME_W-1:0]     div_rem;

   ftfp_pkg::state_type              state_ff, state_in;
   logic                             primed_ff, primed_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [NOW_W-1:0]                 now_ff, now_in;
   logic [NOW_W-1:0]                 last_ff, last_in;
   logic [NOW_W-1:0]                 elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]             sim_acc_ff, sim_acc_in;
   logic [TIME_BITS-1:0]             disp_acc_ff, disp_acc_in;
   logic [PROD_W-1:0]                prod_ff, prod_in;
   logic [WIDE_W-1:0]                sim_tgt_ff, sim_tgt_in;
   logic [WIDE_W-1:0]                disp_tgt_ff, disp_tgt_in;
   logic [WAKE_W-1:0]                sim_wake_ff, sim_wake_in;
   logic [WAKE_W-1:0]                disp_wake_ff, disp_wake_in;
   logic [RUNS_W-1:0]                runs_ff, runs_in;
   logic                             disp_run_ff, disp_run_in;
   logic [RUNS_W-1:0]                rsp_runs_ff, rsp_runs_in;
   logic                             rsp_disp_ff, rsp_disp_in;
   logic [LERP_W-1:0]                rsp_lerp_ff, rsp_lerp_in;
   logic [WAKE_W-1:0]                rsp_wake_ff, rsp_wake_in;

   logic                             req_ready;
   logic                             div_start;
   logic                             rsp_load;

   logic                             sim_capped;
   logic                             disp_capped;
   logic                             quo_ge;
   logic                             lerp_one;
   logic [SUM_W-1:0]                 sim_sum, disp_sum;
   logic [TIME_BITS-1:0]             sim_sat, disp_sat;
   logic [FRACTION_BITS:0]           lerp_full;
   logic [FRACTION_BITS+LERP_W:0]    lerp_ext;
   logic [WAKE_W-1:0]                wake_min;

   ftfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ftfp_div #(
      .TIME_BITS     (TIME_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sim_acc_ff),
      .divisor  (cfg.sim_eff),
      .status   (div_st),
      .frac     (div_frac),
      .rem      (div_rem)
   );

   // target - accum, zero when already due, clamped to the output range
   function automatic logic [WAKE_W-1:0] next_wake(input logic [WIDE_W-1:0]    target,
                                                   input logic [TIME_BITS-1:0] acc);
      logic [WIDE_W-1:0] acc_w;
      logic [WIDE_W-1:0] diff;
      acc_w = WIDE_W'(acc);
      diff  = target - acc_w;
      if (acc_w >= target)
         next_wake = '0;
      else if (diff[WIDE_W-1])
         next_wake = '1;
      else
         next_wake = diff[WAKE_W-1:0];
   endfunction

   assign sim_capped  = !cfg.benchmark;
   assign disp_capped = !cfg.benchmark && cfg.display_capped;
   assign quo_ge      = div_st.quo_big || (div_st.quo_low >= cfg.catch_up);

   assign sim_sum  = SUM_W'(sim_acc_ff) + SUM_W'(elapsed_ff);
   assign disp_sum = SUM_W'(disp_acc_ff) + SUM_W'(elapsed_ff);
   assign sim_sat  = (sim_sum[SUM_W-1:TIME_BITS] != '0) ? '1 : sim_sum[TIME_BITS-1:0];
   assign disp_sat = (disp_sum[SUM_W-1:TIME_BITS] != '0) ? '1 : disp_sum[TIME_BITS-1:0];

   assign lerp_one  = cfg.benchmark || cfg.single_step ||
                      (cfg.display_capped && (cfg.sim_frame == cfg.disp_frame));
   assign lerp_full = lerp_one ? {1'b1, {FRACTION_BITS{1'b0}}} : {1'b0, div_frac};
   assign lerp_ext  = {{LERP_W{1'b0}}, lerp_full};
   assign wake_min  = (sim_wake_ff < disp_wake_ff) ? sim_wake_ff : disp_wake_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ftfp_pkg::ST_IDLE:   if (req_ch.valid) state_in = ftfp_pkg::ST_ELAPSE;
         ftfp_pkg::ST_ELAPSE: state_in = ftfp_pkg::ST_ACCUM;
         ftfp_pkg::ST_ACCUM:  state_in = ftfp_pkg::ST_DISP;
         ftfp_pkg::ST_DISP:   state_in = ftfp_pkg::ST_DIV;
         ftfp_pkg::ST_DIV:    if (div_st.done) state_in = ftfp_pkg::ST_SETTLE;
         ftfp_pkg::ST_SETTLE: state_in = ftfp_pkg::ST_WAKE;
         ftfp_pkg::ST_WAKE:   state_in = ftfp_pkg::ST_FINISH;
         ftfp_pkg::ST_FINISH: if (rsp_load) state_in = ftfp_pkg::ST_IDLE;
         default:             state_in = ftfp_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ftfp_pkg::ST_IDLE:   req_ready = 1'b1;
         ftfp_pkg::ST_DISP:   div_start = 1'b1;
         ftfp_pkg::ST_FINISH: rsp_load  = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      primed_in    = primed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      now_in       = now_ff;
      last_in      = last_ff;
      elapsed_in   = elapsed_ff;
      sim_acc_in   = sim_acc_ff;
      disp_acc_in  = disp_acc_ff;
      prod_in      = prod_ff;
      sim_tgt_in   = sim_tgt_ff;
      disp_tgt_in  = disp_tgt_ff;
      sim_wake_in  = sim_wake_ff;
      disp_wake_in = disp_wake_ff;
      runs_in      = runs_ff;
      disp_run_in  = disp_run_ff;
      rsp_runs_in  = rsp_runs_ff;
      rsp_disp_in  = rsp_disp_ff;
      rsp_lerp_in  = rsp_lerp_ff;
      rsp_wake_in  = rsp_wake_ff;
      unique case (state_ff)
         ftfp_pkg::ST_IDLE: begin
            if (req_ready && req_ch.valid) begin
               now_in  = req_ch.now_ns;
               prod_in = PROD_W'(cfg.catch_up) * PROD_W'(cfg.sim_eff);
               // first request: one frame in each accumulator, zero elapsed
               if (!primed_ff) begin
                  primed_in   = 1'b1;
                  sim_acc_in  = TIME_BITS'(cfg.sim_eff);
                  disp_acc_in = TIME_BITS'(cfg.disp_eff);
                  last_in     = req_ch.now_ns;
               end
            end
         end
         ftfp_pkg::ST_ELAPSE: begin
            elapsed_in  = (now_ff >= last_ff) ? (now_ff - last_ff) : '0;
            last_in     = now_ff;
            sim_tgt_in  = WIDE_W'(now_ff) + WIDE_W'(cfg.sim_eff);
            disp_tgt_in = WIDE_W'(now_ff) + WIDE_W'(cfg.disp_eff);
         end
         ftfp_pkg::ST_ACCUM: begin
            sim_acc_in  = sim_capped ? sim_sat : TIME_BITS'(cfg.sim_eff);
            disp_acc_in = disp_capped ? disp_sat : TIME_BITS'(cfg.disp_eff);
         end
         ftfp_pkg::ST_DISP: begin
            disp_run_in = 1'b1;
            if (disp_capped) begin
               if (disp_acc_ff >= TIME_BITS'(cfg.disp_eff))
                  disp_acc_in = disp_acc_ff - TIME_BITS'(cfg.disp_eff);
               else
                  disp_run_in = 1'b0;
            end
         end
         ftfp_pkg::ST_DIV: ;
         ftfp_pkg::ST_SETTLE: begin
            if (sim_capped) begin
               // at the catch-up limit the excess frames stay in the accumulator
               if (quo_ge) begin
                  sim_acc_in = sim_acc_ff - TIME_BITS'(prod_ff);
                  runs_in    = cfg.catch_up;
               end else begin
                  sim_acc_in = TIME_BITS'(div_rem);
                  runs_in    = div_st.quo_low;
               end
            end else begin
               runs_in = RUNS_W'(1);
            end
         end
         ftfp_pkg::ST_WAKE: begin
            sim_wake_in  = sim_capped ? next_wake(sim_tgt_ff, sim_acc_ff) : now_ff;
            disp_wake_in = disp_capped ? next_wake(disp_tgt_ff, disp_acc_ff) : now_ff;
         end
         ftfp_pkg::ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_runs_in  = runs_ff;
               rsp_disp_in  = disp_run_ff;
               rsp_lerp_in  = lerp_ext[LERP_W-1:0];
               rsp_wake_in  = wake_min;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftfp_pkg::ST_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      last_ff      <= last_in;
      elapsed_ff   <= elapsed_in;
      sim_acc_ff   <= sim_acc_in;
      disp_acc_ff  <= disp_acc_in;
      prod_ff      <= prod_in;
      sim_tgt_ff   <= sim_tgt_in;
      disp_tgt_ff  <= disp_tgt_in;
      sim_wake_ff  <= sim_wake_in;
      disp_wake_ff <= disp_wake_in;
      runs_ff      <= runs_in;
      disp_run_ff  <= disp_run_in;
      rsp_runs_ff  <= rsp_runs_in;
      rsp_disp_ff  <= rsp_disp_in;
      rsp_lerp_ff  <= rsp_lerp_in;
      rsp_wake_ff  <= rsp_wake_in;
   end

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sim_runs      = rsp_runs_ff;
   assign rsp_ch.display_run   = rsp_disp_ff;
   assign rsp_ch.lerp_fraction = rsp_lerp_ff;
   assign rsp_ch.wake_time_ns  = rsp_wake_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == ftfp_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   a_runs_within_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ftfp_pkg::ST_WAKE) && sim_capped |-> runs_ff <= cfg.catch_up)
      else $error("simulation runs exceed the catch-up limit");

   a_remainder_below_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ftfp_pkg::ST_WAKE) && sim_capped && (runs_ff < cfg.catch_up)
      |-> sim_acc_ff < TIME_BITS'(cfg.sim_eff))
      else $error("simulation accumulator holds a whole frame below the limit");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ftfp_pkg::ST_FINISH)
      else $error("result raised outside the finish state");

endmodule
